// ===== rtl/smooth_l1_loss_and_gradient_core_macros.svh =====
// Assertion macros used by the checker file of the smooth L1 core.
// Needs clk, and rst_n for SL1_ASSERT, in the scope where a macro is used.
`ifndef SMOOTH_L1_LOSS_AND_GRADIENT_CORE_MACROS_SVH
`define SMOOTH_L1_LOSS_AND_GRADIENT_CORE_MACROS_SVH

// Checked outside reset only.
`define SL1_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SL1_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sl1_pkg.sv =====
// Types and constants of the smooth L1 loss and gradient core.
// No dependencies; used by every other file of the block but the macro header.
package sl1_pkg;

  localparam int QW  = 31;        // unsigned Q15.16 register / loss width
  localparam int DW  = 32;        // signed Q16.16 data width
  localparam int MW  = 2 * QW;    // one 31x31 product
  localparam int PW  = 3 * QW;    // full 93-bit triple product
  localparam int CIW = 2;         // config index width

  localparam logic [CIW-1:0] CFG_BETA       = 2'd0;
  localparam logic [CIW-1:0] CFG_INV_BETA   = 2'd1;
  localparam logic [CIW-1:0] CFG_LOSS_SCALE = 2'd2;

  localparam logic [QW-1:0] CFG_RESET_VAL = 31'd65536;

  typedef logic [QW-1:0]        q31_t;
  typedef logic signed [DW-1:0] q32s_t;
  typedef logic [MW-1:0]        prod_t;

  typedef struct packed {
    q31_t beta;
    q31_t inv_beta;
    q31_t loss_scale;
  } cfg_t;

  // advance enable and incoming valid for one pipeline stage
  typedef struct packed {
    logic adv;
    logic vld;
  } stg_ctl_t;

  // fields that ride along the pipe unchanged after the front stage
  typedef struct packed {
    logic neg;
    logic quad;
    logic nz;
    q31_t lin_loss;
    logic lin_clip;
  } side_t;

  typedef struct packed {
    side_t side;
    q31_t  mag;
  } s1_t;

  typedef struct packed {
    side_t side;
    prod_t sq;
    prod_t ga;
  } s2_t;

  typedef struct packed {
    side_t side;
    prod_t sq_hi;
    prod_t sq_lo;
    prod_t ga_hi;
    prod_t ga_lo;
  } s3_t;

  typedef struct packed {
    q31_t  loss;
    q32s_t gradient;
    logic  clipped;
  } res_t;

endpackage

// ===== rtl/sl1_ifs.sv =====
// Valid/ready channel interfaces of the smooth L1 core: input, result, config.
// Depends on sl1_pkg for the payload types.
interface sl1_in_if;
  import sl1_pkg::*;
  logic  valid;
  logic  ready;
  q32s_t prediction;
  q32s_t label;
  modport source (output valid, prediction, label, input ready);
  modport sink (input valid, prediction, label, output ready);
endinterface

interface sl1_out_if;
  import sl1_pkg::*;
  logic  valid;
  logic  ready;
  q31_t  loss;
  q32s_t gradient;
  logic  clipped;
  modport source (output valid, loss, gradient, clipped, input ready);
  modport sink (input valid, loss, gradient, clipped, output ready);
endinterface

interface sl1_cfg_if;
  import sl1_pkg::*;
  logic           valid;
  logic           ready;
  logic [CIW-1:0] index;
  logic [DW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/sl1_front.sv =====
// Stage 1: difference, magnitude, region select and the whole linear-region loss.
// Depends on sl1_pkg.
module sl1_front (
  input  logic             clk,
  input  logic             rst_n,
  input  sl1_pkg::stg_ctl_t ctl_i,
  input  sl1_pkg::q32s_t   prediction,
  input  sl1_pkg::q32s_t   label,
  input  sl1_pkg::q31_t    beta,
  output logic             vld_o,
  output sl1_pkg::s1_t     st_o
);
  import sl1_pkg::*;

  logic [DW:0]   diff;
  logic [DW:0]   absd;
  logic [DW:0]   lin;
  logic [QW-1:0] half;
  s1_t           st_nxt;
  s1_t           st_r;
  logic          vld_r;

  always_comb begin
    diff = {prediction[DW-1], prediction} - {label[DW-1], label};
    absd = diff[DW] ? ((DW+1)'(0) - diff) : diff;
    // ceil(beta/2)
    half = QW'(({1'b0, beta} + (QW+1)'(1)) >> 1);
    lin  = absd - {2'b00, half};
    st_nxt.side.neg      = diff[DW];
    st_nxt.side.quad     = absd < {2'b00, beta};
    st_nxt.side.nz       = |absd;
    st_nxt.side.lin_clip = |lin[DW:QW];
    st_nxt.side.lin_loss = st_nxt.side.lin_clip ? '1 : lin[QW-1:0];
    // in the quadratic region |diff| < beta < 2^31
    st_nxt.mag           = absd[QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      st_r <= st_nxt;
    end
  end

  assign vld_o = vld_r;
  assign st_o  = st_r;
endmodule

// ===== rtl/sl1_sq.sv =====
// Stage 2: first multiply level, |diff|^2 and |diff| * inv_beta.
// Depends on sl1_pkg.
module sl1_sq (
  input  logic              clk,
  input  logic              rst_n,
  input  sl1_pkg::stg_ctl_t ctl_i,
  input  sl1_pkg::s1_t      st_i,
  input  sl1_pkg::q31_t     inv_beta,
  output logic              vld_o,
  output sl1_pkg::s2_t      st_o
);
  import sl1_pkg::*;

  s2_t  st_nxt;
  s2_t  st_r;
  logic vld_r;

  always_comb begin
    st_nxt.side = st_i.side;
    st_nxt.sq   = {{QW{1'b0}}, st_i.mag} * {{QW{1'b0}}, st_i.mag};
    st_nxt.ga   = {{QW{1'b0}}, st_i.mag} * {{QW{1'b0}}, inv_beta};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      st_r <= st_nxt;
    end
  end

  assign vld_o = vld_r;
  assign st_o  = st_r;
endmodule

// ===== rtl/sl1_prod.sv =====
// Stage 3: second multiply level as four 31x31 partial products
// (square by inv_beta, |diff|*inv_beta by loss_scale). Depends on sl1_pkg.
module sl1_prod (
  input  logic              clk,
  input  logic              rst_n,
  input  sl1_pkg::stg_ctl_t ctl_i,
  input  sl1_pkg::s2_t      st_i,
  input  sl1_pkg::q31_t     inv_beta,
  input  sl1_pkg::q31_t     loss_scale,
  output logic              vld_o,
  output sl1_pkg::s3_t      st_o
);
  import sl1_pkg::*;

  s3_t  st_nxt;
  s3_t  st_r;
  logic vld_r;

  function automatic prod_t mul31(input q31_t a, input q31_t b);
    return {{QW{1'b0}}, a} * {{QW{1'b0}}, b};
  endfunction

  always_comb begin
    st_nxt.side  = st_i.side;
    st_nxt.sq_hi = mul31(st_i.sq[MW-1:QW], inv_beta);
    st_nxt.sq_lo = mul31(st_i.sq[QW-1:0], inv_beta);
    st_nxt.ga_hi = mul31(st_i.ga[MW-1:QW], loss_scale);
    st_nxt.ga_lo = mul31(st_i.ga[QW-1:0], loss_scale);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      st_r <= st_nxt;
    end
  end

  assign vld_o = vld_r;
  assign st_o  = st_r;
endmodule

// ===== rtl/sl1_sat.sv =====
// Stage 4: partial product sum, shift, saturation, region mux and sign.
// Its register is the output register of the core. Depends on sl1_pkg.
module sl1_sat (
  input  logic              clk,
  input  logic              rst_n,
  input  sl1_pkg::stg_ctl_t ctl_i,
  input  sl1_pkg::s3_t      st_i,
  input  sl1_pkg::q31_t     loss_scale,
  output logic              vld_o,
  output sl1_pkg::res_t     res_o
);
  import sl1_pkg::*;

  logic [PW-1:0] psq;
  logic [PW-1:0] pga;
  logic          qloss_clip;
  q31_t          qloss;
  logic [DW-1:0] gr;
  logic [DW-1:0] lim;
  logic          gclip;
  logic [DW-1:0] qmag;
  logic [DW-1:0] mag;
  res_t          res_nxt;
  res_t          res_r;
  logic          vld_r;

  always_comb begin
    psq = {st_i.sq_hi, {QW{1'b0}}} + {{QW{1'b0}}, st_i.sq_lo};
    pga = {st_i.ga_hi, {QW{1'b0}}} + {{QW{1'b0}}, st_i.ga_lo};

    // loss = floor(psq / 2^33)
    qloss_clip = |psq[PW-1:64];
    qloss      = qloss_clip ? '1 : psq[63:33];

    // gradient magnitude = floor(pga / 2^32), limit depends on sign
    gr    = pga[63:32];
    lim   = st_i.side.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    gclip = (|pga[PW-1:64]) || (gr > lim);
    qmag  = gclip ? lim : gr;

    if (st_i.side.quad) begin
      mag             = qmag;
      res_nxt.loss    = qloss;
      res_nxt.clipped = qloss_clip | gclip;
    end else begin
      mag             = st_i.side.nz ? {1'b0, loss_scale} : '0;
      res_nxt.loss    = st_i.side.lin_loss;
      res_nxt.clipped = st_i.side.lin_clip;
    end
    res_nxt.gradient = st_i.side.neg ? q32s_t'(DW'(0) - mag) : q32s_t'(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      res_r <= res_nxt;
    end
  end

  assign vld_o = vld_r;
  assign res_o = res_r;
endmodule

// ===== rtl/smooth_l1_loss_and_gradient_core.sv =====
// Smooth L1 (Huber) loss and scaled gradient, one element per word. The core
// is a four-stage pipeline (difference, first multiply, second multiply as
// 31x31 partial products, sum and saturate) and takes one word every cycle
// while out_ch.ready is high; the input word is registered at its accepting
// edge and moves through the stage 2, 3 and 4 registers to out_ch, waiting
// only while out_ch.ready is held low. Stalls back up stage by stage, so bubbles
// are squeezed out before in_ch.ready drops. beta, inv_beta and loss_scale
// are written through cfg_ch (always ready) and must only change while the
// pipeline is empty. Depends on sl1_pkg, sl1_ifs and the stage modules.
module smooth_l1_loss_and_gradient_core (
  input  logic       clk,
  input  logic       rst_n,
  sl1_in_if.sink     in_ch,
  sl1_out_if.source  out_ch,
  sl1_cfg_if.sink    cfg_ch
);
  import sl1_pkg::*;

  cfg_t     cfg_r;
  logic     v1, v2, v3, v4;
  logic     rdy1, rdy2, rdy3, rdy4;
  stg_ctl_t ctl1, ctl2, ctl3, ctl4;
  s1_t      s1;
  s2_t      s2;
  s3_t      s3;
  res_t     res;

  // config registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.beta       <= CFG_RESET_VAL;
      cfg_r.inv_beta   <= CFG_RESET_VAL;
      cfg_r.loss_scale <= CFG_RESET_VAL;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_BETA:       cfg_r.beta       <= cfg_ch.data[QW-1:0];
        CFG_INV_BETA:   cfg_r.inv_beta   <= cfg_ch.data[QW-1:0];
        CFG_LOSS_SCALE: cfg_r.loss_scale <= cfg_ch.data[QW-1:0];
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its content moves on
  assign rdy4 = !v4 || out_ch.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign ctl1 = '{adv: rdy1, vld: in_ch.valid};
  assign ctl2 = '{adv: rdy2, vld: v1};
  assign ctl3 = '{adv: rdy3, vld: v2};
  assign ctl4 = '{adv: rdy4, vld: v3};

  assign in_ch.ready = rdy1;

  sl1_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl1),
    .prediction (in_ch.prediction),
    .label      (in_ch.label),
    .beta       (cfg_r.beta),
    .vld_o      (v1),
    .st_o       (s1)
  );

  sl1_sq u_sq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl2),
    .st_i     (s1),
    .inv_beta (cfg_r.inv_beta),
    .vld_o    (v2),
    .st_o     (s2)
  );

  sl1_prod u_prod (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl3),
    .st_i       (s2),
    .inv_beta   (cfg_r.inv_beta),
    .loss_scale (cfg_r.loss_scale),
    .vld_o      (v3),
    .st_o       (s3)
  );

  sl1_sat u_sat (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl4),
    .st_i       (s3),
    .loss_scale (cfg_r.loss_scale),
    .vld_o      (v4),
    .res_o      (res)
  );

  assign out_ch.valid    = v4;
  assign out_ch.loss     = res.loss;
  assign out_ch.gradient = res.gradient;
  assign out_ch.clipped  = res.clipped;
endmodule

// ===== rtl/sl1_checker.sv =====
// Port-level checks of the smooth L1 core, bound to the top level.
// Depends on sl1_pkg and the assertion macro header.
`include "smooth_l1_loss_and_gradient_core_macros.svh"

module sl1_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input sl1_pkg::q31_t  out_loss,
  input sl1_pkg::q32s_t out_gradient,
  input logic           out_clipped
);
  import sl1_pkg::*;

  // a held result word keeps its payload
  `SL1_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_loss) && $stable(out_gradient) && $stable(out_clipped), "result word changed under stall")
  // reset empties the pipe
  `SL1_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")
  // a draining output must open the input side in the same cycle
  `SL1_ASSERT_ALWAYS(a_ready_chain, out_ready |-> in_ready, "input stalled while output drains")
endmodule

bind smooth_l1_loss_and_gradient_core sl1_checker u_sl1_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_loss     (out_ch.loss),
  .out_gradient (out_ch.gradient),
  .out_clipped  (out_ch.clipped)
);
